// ===== rtl/nif_pkg.sv =====
// Package for the nearest icosahedron face block.
// Holds the shared constants, command and status types and the series divisor function.
// No dependencies.
package nif_pkg;

    localparam int NUM_FACES_DEF = 20;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FACE_W        = 5;
    localparam int SER_TERMS     = 12;
    localparam int DIV_DEN_W     = 10;
    localparam int DIV_STEP      = 4;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
    localparam logic [63:0] DEGQ    = (PI_Q62 + 64'd90) / 64'd180;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MS_RAD,
        MS_SQ,
        MS_SER
    } mul_sel_t;

    typedef enum logic [2:0] {
        SM_PX,
        SM_PY,
        SM_DX,
        SM_DY,
        SM_DZ
    } smul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_M,
        ST_RED_Q,
        ST_RAD_GO,
        ST_RAD_W,
        ST_SQ_GO,
        ST_SQ_W,
        ST_SER_INIT,
        ST_SER_MGO,
        ST_SER_MW,
        ST_SER_DW,
        ST_SER_END,
        ST_FIN,
        ST_PX,
        ST_PY,
        ST_PZ,
        ST_DRD,
        ST_DM0,
        ST_DM1,
        ST_DM2,
        ST_DM3,
        ST_DCMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      store_wr;
        logic      red_m;
        logic      red_q;
        logic      mul_start;
        mul_sel_t  mul_sel;
        logic      th_load;
        logic      th2_load;
        logic      ser_init;
        logic      div_start;
        logic      ser_upd;
        logic      ser_save;
        logic      fin;
        logic      is_lat;
        logic      is_cos;
        logic [3:0] n;
        logic      smul;
        smul_sel_t smul_sel;
        logic      px_load;
        logic      py_load;
        logic      rd_en;
        logic      acc_first;
        logic      acc_add;
        logic      cmp;
        logic      cmp_first;
        logic      face_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } status_t;

    // Divisor of term n: (2n)(2n+1) for the sine series, (2n-1)(2n) for the cosine series.
    function automatic logic [DIV_DEN_W-1:0] series_den(input logic [3:0] n, input logic is_cos);
        logic [DIV_DEN_W-1:0] a;
        a = DIV_DEN_W'({n, 1'b0});
        if (is_cos)
        begin
            return DIV_DEN_W'((a - DIV_DEN_W'(1)) * a);
        end
        return DIV_DEN_W'(a * (a + DIV_DEN_W'(1)));
    endfunction

endpackage

// ===== rtl/nif_mul.sv =====
// Iterative 64 by 64 bit unsigned multiplier, one 32 by 32 partial product per cycle.
// Depends on nothing outside this file.
module nif_mul
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output logic         done
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [6:0]   sh;

    always_comb
    begin
        pa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        sh = 7'({cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0]}) << 5;
        acc_next = acc_reg + (128'(pp) << sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/nif_div.sv =====
// Serial divider of a 64-bit value by a small constant divisor, four quotient bits a cycle.
// Depends on nif_pkg.
module nif_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [63:0]                   num,
    input  logic [nif_pkg::DIV_DEN_W-1:0] den,
    output logic [63:0]                   quo,
    output logic                          done
);

    localparam int STEPS = 64 / nif_pkg::DIV_STEP;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = nif_pkg::DIV_DEN_W;

    logic [63:0]    sh_reg;
    logic [63:0]    sh_next;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  rem_next;
    logic [DW-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DW:0]    r;
    logic [63:0]    s;

    always_comb
    begin
        r = {1'b0, rem_reg};
        s = sh_reg;
        for (int k = 0; k < nif_pkg::DIV_STEP; k++)
        begin
            r = {r[DW-1:0], s[63]};
            s = {s[62:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r    = r - {1'b0, den_reg};
                s[0] = 1'b1;
            end
        end
        rem_next = r[DW-1:0];
        sh_next  = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = sh_reg;
    assign done = done_reg;

endmodule

// ===== rtl/nif_datapath.sv =====
// Datapath: centre store, angle reduction, sine and cosine series, point vector and dot products.
// Depends on nif_pkg, nif_mul and nif_div.
module nif_datapath
#(
    parameter int NUM_FACES = nif_pkg::NUM_FACES_DEF,
    parameter int FRAC_BITS = nif_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nif_pkg::cmd_t                     cmd,
    input  logic [$clog2(NUM_FACES)-1:0]      idx,
    output nif_pkg::status_t                  status,
    input  logic [4:0]                        face_slot,
    input  logic signed [FRAC_BITS+1:0]       centre_x,
    input  logic signed [FRAC_BITS+1:0]       centre_y,
    input  logic signed [FRAC_BITS+1:0]       centre_z,
    input  logic signed [FRAC_BITS+8:0]       point_lon,
    input  logic signed [FRAC_BITS+7:0]       point_lat,
    output logic [nif_pkg::FACE_W-1:0]        face
);

    localparam int SW    = FRAC_BITS + 2;
    localparam int AW    = FRAC_BITS + 9;
    localparam int LATW  = FRAC_BITS + 8;
    localparam int RW    = FRAC_BITS + 7;
    localparam int RRW   = FRAC_BITS + 6;
    localparam int IDX_W = $clog2(NUM_FACES);
    localparam int DW    = 2 * SW + 2;
    localparam int SH    = 62 - FRAC_BITS;

    localparam logic signed [AW:0] FULL   = (AW + 1)'(64'd360 << FRAC_BITS);
    localparam logic [AW-1:0]      QUAD1  = AW'(64'd90 << FRAC_BITS);
    localparam logic [AW-1:0]      QUAD2  = AW'(64'd180 << FRAC_BITS);
    localparam logic [AW-1:0]      QUAD3  = AW'(64'd270 << FRAC_BITS);
    localparam logic [RW-1:0]      QUAD_R = RW'(64'd90 << FRAC_BITS);
    localparam logic [RW-1:0]      HALF_R = RW'(64'd45 << FRAC_BITS);
    localparam logic signed [2*SW-1:0] RND_HALF = (2 * SW)'(64'd1 << (FRAC_BITS - 1));
    localparam logic [63:0]        FIX_HALF = 64'd1 << (SH - 1);

    function automatic logic signed [SW-1:0] to_fix(input logic [63:0] v);
        logic [63:0] s;
        s = v + FIX_HALF;
        return $signed(s[63:SH]);
    endfunction

    logic signed [AW-1:0]   lon_reg;
    logic signed [LATW-1:0] lat_reg;
    logic [AW-1:0]          m_reg;
    logic [1:0]             q_reg;
    logic                   fold_reg;
    logic [RRW-1:0]         rr_reg;
    logic [63:0]            th_reg;
    logic [63:0]            th2_reg;
    logic [63:0]            t_reg;
    logic [63:0]            sum_reg;
    logic [63:0]            sq_reg;
    logic [63:0]            cq_reg;
    logic signed [SW-1:0]   slon_reg;
    logic signed [SW-1:0]   clon_reg;
    logic signed [SW-1:0]   slat_reg;
    logic signed [SW-1:0]   clat_reg;
    logic signed [2*SW-1:0] sm_prod_reg;
    logic signed [SW-1:0]   px_reg;
    logic signed [SW-1:0]   py_reg;
    logic signed [DW-1:0]   acc_reg;
    logic signed [DW-1:0]   best_d_reg;
    logic [IDX_W-1:0]       best_reg;
    logic [3*SW-1:0]        rd_reg;
    logic [nif_pkg::FACE_W-1:0] face_reg;
    logic [3*SW-1:0]        store_mem [NUM_FACES];

    logic signed [AW:0]     a_sel;
    logic signed [AW:0]     m_sum;
    logic [1:0]             q_next;
    logic [AW-1:0]          base;
    logic [AW-1:0]          r_full;
    logic [RW-1:0]          r_q;
    logic                   fold_next;
    logic [RRW-1:0]         rr_next;
    logic signed [SW-1:0]   s0;
    logic signed [SW-1:0]   c0;
    logic signed [SW-1:0]   sn;
    logic signed [SW-1:0]   cs;
    logic signed [SW-1:0]   sm_a;
    logic signed [SW-1:0]   sm_b;
    logic signed [2*SW-1:0] rnd_full;
    logic signed [SW-1:0]   rd_x;
    logic signed [SW-1:0]   rd_y;
    logic signed [SW-1:0]   rd_z;
    logic [63:0]            mul_a;
    logic [63:0]            mul_b;
    logic [127:0]           mul_prod;
    logic                   mul_done;
    logic [63:0]            div_quo;
    logic                   div_done;
    logic [63:0]            p62;

    always_comb
    begin
        a_sel = cmd.is_lat ? (AW + 1)'(lat_reg) : (AW + 1)'(lon_reg);
        m_sum = a_sel[AW] ? a_sel + FULL : a_sel;

        if (m_reg >= QUAD3)
        begin
            q_next = 2'd3;
            base   = QUAD3;
        end
        else if (m_reg >= QUAD2)
        begin
            q_next = 2'd2;
            base   = QUAD2;
        end
        else if (m_reg >= QUAD1)
        begin
            q_next = 2'd1;
            base   = QUAD1;
        end
        else
        begin
            q_next = 2'd0;
            base   = '0;
        end
        r_full    = m_reg - base;
        r_q       = r_full[RW-1:0];
        fold_next = r_q > HALF_R;
        rr_next   = fold_next ? RRW'(QUAD_R - r_q) : r_q[RRW-1:0];
    end

    always_comb
    begin
        s0 = fold_reg ? to_fix(cq_reg) : to_fix(sq_reg);
        c0 = fold_reg ? to_fix(sq_reg) : to_fix(cq_reg);
        case (q_reg)
            2'd0:
            begin
                sn = s0;
                cs = c0;
            end
            2'd1:
            begin
                sn = c0;
                cs = -s0;
            end
            2'd2:
            begin
                sn = -s0;
                cs = -c0;
            end
            default:
            begin
                sn = -c0;
                cs = s0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.mul_sel)
            nif_pkg::MS_RAD:
            begin
                mul_a = 64'(rr_reg);
                mul_b = nif_pkg::DEGQ;
            end
            nif_pkg::MS_SQ:
            begin
                mul_a = th_reg;
                mul_b = th_reg;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = th2_reg;
            end
        endcase
    end

    always_comb
    begin
        rd_x = $signed(rd_reg[SW-1:0]);
        rd_y = $signed(rd_reg[2*SW-1:SW]);
        rd_z = $signed(rd_reg[3*SW-1:2*SW]);
        case (cmd.smul_sel)
            nif_pkg::SM_PX:
            begin
                sm_a = clat_reg;
                sm_b = clon_reg;
            end
            nif_pkg::SM_PY:
            begin
                sm_a = clat_reg;
                sm_b = slon_reg;
            end
            nif_pkg::SM_DX:
            begin
                sm_a = rd_x;
                sm_b = px_reg;
            end
            nif_pkg::SM_DY:
            begin
                sm_a = rd_y;
                sm_b = py_reg;
            end
            default:
            begin
                sm_a = rd_z;
                sm_b = slat_reg;
            end
        endcase
        rnd_full = (sm_prod_reg + RND_HALF) >>> FRAC_BITS;
    end

    assign p62 = mul_prod[125:62];

    nif_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    nif_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (p62),
        .den   (nif_pkg::series_den(cmd.n, cmd.is_cos)),
        .quo   (div_quo),
        .done  (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr && (32'(face_slot) < NUM_FACES))
        begin
            store_mem[IDX_W'(face_slot)] <= {centre_z, centre_y, centre_x};
        end
        if (cmd.rd_en)
        begin
            rd_reg <= store_mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lon_reg <= point_lon;
            lat_reg <= point_lat;
        end
        if (cmd.red_m)
        begin
            m_reg <= m_sum[AW-1:0];
        end
        if (cmd.red_q)
        begin
            q_reg    <= q_next;
            fold_reg <= fold_next;
            rr_reg   <= rr_next;
        end
        if (cmd.th_load)
        begin
            th_reg <= mul_prod[FRAC_BITS+63:FRAC_BITS];
        end
        if (cmd.th2_load)
        begin
            th2_reg <= p62;
        end
        if (cmd.ser_init)
        begin
            t_reg   <= cmd.is_cos ? nif_pkg::ONE_Q62 : th_reg;
            sum_reg <= cmd.is_cos ? nif_pkg::ONE_Q62 : th_reg;
        end
        else if (cmd.ser_upd)
        begin
            t_reg   <= div_quo;
            sum_reg <= cmd.n[0] ? sum_reg - div_quo : sum_reg + div_quo;
        end
        if (cmd.ser_save)
        begin
            if (cmd.is_cos)
            begin
                cq_reg <= sum_reg;
            end
            else
            begin
                sq_reg <= sum_reg;
            end
        end
        if (cmd.fin)
        begin
            if (cmd.is_lat)
            begin
                slat_reg <= sn;
                clat_reg <= cs;
            end
            else
            begin
                slon_reg <= sn;
                clon_reg <= cs;
            end
        end
        if (cmd.smul)
        begin
            sm_prod_reg <= sm_a * sm_b;
        end
        if (cmd.px_load)
        begin
            px_reg <= rnd_full[SW-1:0];
        end
        if (cmd.py_load)
        begin
            py_reg <= rnd_full[SW-1:0];
        end
        if (cmd.acc_first)
        begin
            acc_reg <= DW'(sm_prod_reg);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + DW'(sm_prod_reg);
        end
        if (cmd.cmp && (cmd.cmp_first || (acc_reg > best_d_reg)))
        begin
            best_d_reg <= acc_reg;
            best_reg   <= idx;
        end
        if (cmd.face_load)
        begin
            face_reg <= nif_pkg::FACE_W'(best_reg);
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign face            = face_reg;

endmodule

// ===== rtl/nif_ctrl.sv =====
// Controller state machine: sequences the reduction, series, point vector and face scan.
// Depends on nif_pkg.
module nif_ctrl
#(
    parameter int NUM_FACES = nif_pkg::NUM_FACES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         op,
    output logic                         in_stall,
    output logic                         out_valid,
    input  logic                         out_stall,
    input  nif_pkg::status_t             status,
    output nif_pkg::cmd_t                cmd,
    output logic [$clog2(NUM_FACES)-1:0] idx
);

    localparam int IDX_W = $clog2(NUM_FACES);

    nif_pkg::state_t  state_reg;
    nif_pkg::state_t  state_next;
    logic [3:0]       n_reg;
    logic [3:0]       n_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             is_lat_reg;
    logic             is_lat_next;
    logic             is_cos_reg;
    logic             is_cos_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nif_pkg::ST_IDLE;
            n_reg         <= 4'd0;
            idx_reg       <= '0;
            is_lat_reg    <= 1'b0;
            is_cos_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            is_lat_reg    <= is_lat_next;
            is_cos_reg    <= is_cos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        is_lat_next    = is_lat_reg;
        is_cos_next    = is_cos_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.is_lat     = is_lat_reg;
        cmd.is_cos     = is_cos_reg;
        cmd.n          = n_reg;

        unique case (state_reg)
            nif_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == nif_pkg::OP_QUERY)
                    begin
                        cmd.capture = 1'b1;
                        is_lat_next = 1'b0;
                        state_next  = nif_pkg::ST_RED_M;
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            nif_pkg::ST_RED_M:
            begin
                cmd.red_m  = 1'b1;
                state_next = nif_pkg::ST_RED_Q;
            end
            nif_pkg::ST_RED_Q:
            begin
                cmd.red_q  = 1'b1;
                state_next = nif_pkg::ST_RAD_GO;
            end
            nif_pkg::ST_RAD_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = nif_pkg::MS_RAD;
                state_next    = nif_pkg::ST_RAD_W;
            end
            nif_pkg::ST_RAD_W:
            begin
                if (status.mul_done)
                begin
                    cmd.th_load = 1'b1;
                    state_next  = nif_pkg::ST_SQ_GO;
                end
            end
            nif_pkg::ST_SQ_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = nif_pkg::MS_SQ;
                state_next    = nif_pkg::ST_SQ_W;
            end
            nif_pkg::ST_SQ_W:
            begin
                if (status.mul_done)
                begin
                    cmd.th2_load = 1'b1;
                    is_cos_next  = 1'b0;
                    state_next   = nif_pkg::ST_SER_INIT;
                end
            end
            nif_pkg::ST_SER_INIT:
            begin
                cmd.ser_init = 1'b1;
                n_next       = 4'd1;
                state_next   = nif_pkg::ST_SER_MGO;
            end
            nif_pkg::ST_SER_MGO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = nif_pkg::MS_SER;
                state_next    = nif_pkg::ST_SER_MW;
            end
            nif_pkg::ST_SER_MW:
            begin
                if (status.mul_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = nif_pkg::ST_SER_DW;
                end
            end
            nif_pkg::ST_SER_DW:
            begin
                if (status.div_done)
                begin
                    cmd.ser_upd = 1'b1;
                    if (n_reg == 4'(nif_pkg::SER_TERMS))
                    begin
                        state_next = nif_pkg::ST_SER_END;
                    end
                    else
                    begin
                        n_next     = n_reg + 4'd1;
                        state_next = nif_pkg::ST_SER_MGO;
                    end
                end
            end
            nif_pkg::ST_SER_END:
            begin
                cmd.ser_save = 1'b1;
                if (!is_cos_reg)
                begin
                    is_cos_next = 1'b1;
                    state_next  = nif_pkg::ST_SER_INIT;
                end
                else
                begin
                    state_next = nif_pkg::ST_FIN;
                end
            end
            nif_pkg::ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (!is_lat_reg)
                begin
                    is_lat_next = 1'b1;
                    state_next  = nif_pkg::ST_RED_M;
                end
                else
                begin
                    state_next = nif_pkg::ST_PX;
                end
            end
            nif_pkg::ST_PX:
            begin
                cmd.smul     = 1'b1;
                cmd.smul_sel = nif_pkg::SM_PX;
                state_next   = nif_pkg::ST_PY;
            end
            nif_pkg::ST_PY:
            begin
                cmd.px_load  = 1'b1;
                cmd.smul     = 1'b1;
                cmd.smul_sel = nif_pkg::SM_PY;
                state_next   = nif_pkg::ST_PZ;
            end
            nif_pkg::ST_PZ:
            begin
                cmd.py_load = 1'b1;
                idx_next    = '0;
                state_next  = nif_pkg::ST_DRD;
            end
            nif_pkg::ST_DRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = nif_pkg::ST_DM0;
            end
            nif_pkg::ST_DM0:
            begin
                cmd.smul     = 1'b1;
                cmd.smul_sel = nif_pkg::SM_DX;
                state_next   = nif_pkg::ST_DM1;
            end
            nif_pkg::ST_DM1:
            begin
                cmd.acc_first = 1'b1;
                cmd.smul      = 1'b1;
                cmd.smul_sel  = nif_pkg::SM_DY;
                state_next    = nif_pkg::ST_DM2;
            end
            nif_pkg::ST_DM2:
            begin
                cmd.acc_add  = 1'b1;
                cmd.smul     = 1'b1;
                cmd.smul_sel = nif_pkg::SM_DZ;
                state_next   = nif_pkg::ST_DM3;
            end
            nif_pkg::ST_DM3:
            begin
                cmd.acc_add = 1'b1;
                state_next  = nif_pkg::ST_DCMP;
            end
            nif_pkg::ST_DCMP:
            begin
                cmd.cmp       = 1'b1;
                cmd.cmp_first = (idx_reg == '0);
                if (idx_reg == IDX_W'(NUM_FACES - 1))
                begin
                    state_next = nif_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = nif_pkg::ST_DRD;
                end
            end
            nif_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.face_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = nif_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nif_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != nif_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign idx       = idx_reg;

endmodule

// ===== rtl/nearest_icosa_face_core.sv =====
// Top level of the nearest icosahedron face block.
// Joins the controller nif_ctrl and the datapath nif_datapath; depends on nif_pkg.
//
// The input channel carries two kinds of item. A load item (op low) writes one face
// centre into the store and produces no result. A query item (op high) gives a
// longitude and latitude and produces one result item on the output channel: the
// index of the face whose centre has the largest dot product with the point.
// The next item can be taken in the first cycle that the result is offered. A query
// works through the 24 series terms of each of the two angles, each term one pass
// through the shared 64-bit multiplier (four partial products) and the divider (four
// quotient bits a cycle), and then through the faces one at a time over the single
// store read port and the shared 18-bit multiplier.
// The result waits in an output register, so a stalled receiver does not hold up the
// next query; only a second result that finds the register still full waits for it.
// Reset clears the control state and any waiting result. The centre store is not
// cleared, so every face must be loaded before the first query.
module nearest_icosa_face_core
#(
    parameter int NUM_FACES = nif_pkg::NUM_FACES_DEF,
    parameter int FRAC_BITS = nif_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [4:0]                  face_slot,
    input  logic signed [FRAC_BITS+1:0] centre_x,
    input  logic signed [FRAC_BITS+1:0] centre_y,
    input  logic signed [FRAC_BITS+1:0] centre_z,
    input  logic signed [FRAC_BITS+8:0] point_lon,
    input  logic signed [FRAC_BITS+7:0] point_lat,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [nif_pkg::FACE_W-1:0]  face
);

    nif_pkg::cmd_t                cmd;
    nif_pkg::status_t             status;
    logic [$clog2(NUM_FACES)-1:0] idx;

    nif_ctrl
    #(
        .NUM_FACES (NUM_FACES)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .idx       (idx)
    );

    nif_datapath
    #(
        .NUM_FACES (NUM_FACES),
        .FRAC_BITS (FRAC_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx),
        .status    (status),
        .face_slot (face_slot),
        .centre_x  (centre_x),
        .centre_y  (centre_y),
        .centre_z  (centre_z),
        .point_lon (point_lon),
        .point_lat (point_lat),
        .face      (face)
    );

endmodule
